@@ hw/rtl/rcme_pkg.sv @@
package rcme_pkg;

    localparam int Dim = 16;
    localparam int Cells = Dim * Dim;
    localparam int IdxW = $clog2(Dim);
    localparam int AddrW = $clog2(Cells);
    localparam int DataW = 32;
    localparam int SizeW = 5;
    localparam int PaddrW = 3;

    localparam logic [SizeW-1:0] SizeReset = SizeW'(Dim);
    localparam logic [PaddrW-1:0] RegSizeAddr = 3'd0;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ROW  = 2'd1,
        CMD_COL  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [IdxW-1:0]          line_index;
        logic [IdxW-1:0]          cell_column;
        logic signed [DataW-1:0]  cell_value;
    } in_item_t;

    typedef struct packed {
        logic                     found;
        logic signed [DataW-1:0]  best_value;
    } out_item_t;

    typedef struct packed {
        logic               clear;
        logic               sample;
        logic               live;
        logic [AddrW-1:0]   pos;
    } scan_ctl_t;

endpackage

@@ hw/rtl/rcme_max_unit.sv @@
module rcme_max_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rcme_pkg::scan_ctl_t                  ctl,
    input  logic signed [rcme_pkg::DataW-1:0]    value,
    output logic                                 have,
    output logic signed [rcme_pkg::DataW-1:0]    best_value,
    output logic [rcme_pkg::AddrW-1:0]           best_pos
);

    logic                                 have_reg;
    logic                                 have_next;
    logic signed [rcme_pkg::DataW-1:0]    best_reg;
    logic signed [rcme_pkg::DataW-1:0]    best_next;
    logic [rcme_pkg::AddrW-1:0]           pos_reg;
    logic [rcme_pkg::AddrW-1:0]           pos_next;
    logic                                 take;

    // strict greater keeps the lowest position on ties
    assign take = ctl.sample && ctl.live && (!have_reg || (value > best_reg));

    always_comb
    begin
        have_next = have_reg;
        best_next = best_reg;
        pos_next  = pos_reg;
        if (ctl.clear)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next = 1'b1;
            best_next = value;
            pos_next  = ctl.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        pos_reg  <= pos_next;
    end

    assign have       = have_reg;
    assign best_value = best_reg;
    assign best_pos   = pos_reg;

endmodule

@@ hw/rtl/row_column_max_extract_unit.sv @@
// row/column max extract unit
// holds a 16 x 16 grid of signed 32-bit cells, each with a live mark
// input channel: start, busy, request; an item is taken when start is high
// and busy is low
// load item: writes one cell and marks it live in the accept cycle, busy stays
// low, gives no result
// row or column query: scans the first size_in_use cells of the line (at most 16), one cell
// per cycle through a single registered memory read port and one comparator;
// returns the largest live value and clears its live mark, or not-found if none is live
// a query runs its scan, drain and finish states and then shows done, registered;
// busy is high through those states, so no new item is taken before done shows
// a query with the line outside the size in use answers not-found in the cycle after
// accept and keeps busy low
// result channel: done marks the result for one cycle; the receiver cannot stall
// config: apb port, size_in_use at address 0, reset value 16
// reset clears all live marks and the sequencer and sets the size register to 16
module row_column_max_extract_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  rcme_pkg::in_item_t                    request,
    output logic                                  done,
    output rcme_pkg::out_item_t                   result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rcme_pkg::PaddrW-1:0]           paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    rcme_pkg::state_t                     state_reg;
    rcme_pkg::state_t                     state_next;
    logic [rcme_pkg::SizeW-1:0]           size_reg;
    logic [rcme_pkg::SizeW-1:0]           lim;
    logic [rcme_pkg::IdxW-1:0]            k_reg;
    logic [rcme_pkg::IdxW-1:0]            k_next;
    logic [rcme_pkg::IdxW-1:0]            last_reg;
    logic [rcme_pkg::IdxW-1:0]            last_next;
    logic [rcme_pkg::IdxW-1:0]            line_reg;
    logic [rcme_pkg::IdxW-1:0]            line_next;
    logic                                 col_mode_reg;
    logic                                 col_mode_next;
    logic [rcme_pkg::Cells-1:0]           live_reg;
    logic signed [rcme_pkg::DataW-1:0]    mem [rcme_pkg::Cells];
    logic signed [rcme_pkg::DataW-1:0]    rd_data_reg;
    logic                                 samp_reg;
    logic                                 samp_next;
    logic                                 lv_reg;
    logic [rcme_pkg::AddrW-1:0]           pos_reg;
    logic [rcme_pkg::AddrW-1:0]           rd_addr;
    logic [rcme_pkg::AddrW-1:0]           wr_addr;
    logic                                 wr_en;
    logic                                 kill_live;
    logic                                 clear_max;
    logic                                 done_reg;
    logic                                 done_next;
    logic                                 found_reg;
    logic                                 found_next;
    logic signed [rcme_pkg::DataW-1:0]    best_out_reg;
    logic signed [rcme_pkg::DataW-1:0]    best_out_next;
    logic                                 accept;
    logic                                 cfg_wr;
    rcme_pkg::scan_ctl_t                  ctl;
    logic                                 have;
    logic signed [rcme_pkg::DataW-1:0]    best_value;
    logic [rcme_pkg::AddrW-1:0]           best_pos;

    assign busy   = (state_reg != rcme_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign lim    = (size_reg > rcme_pkg::SizeW'(rcme_pkg::Dim)) ?
                    rcme_pkg::SizeW'(rcme_pkg::Dim) : size_reg;
    assign wr_addr = {request.line_index, request.cell_column};
    assign rd_addr = col_mode_reg ? {k_reg, line_reg} : {line_reg, k_reg};

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == rcme_pkg::RegSizeAddr);
    assign prdata = (paddr == rcme_pkg::RegSizeAddr) ? {27'd0, size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= rcme_pkg::SizeReset;
        end
        else if (cfg_wr)
        begin
            size_reg <= pwdata[rcme_pkg::SizeW-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        last_next     = last_reg;
        line_next     = line_reg;
        col_mode_next = col_mode_reg;
        samp_next     = 1'b0;
        wr_en         = 1'b0;
        kill_live     = 1'b0;
        clear_max     = 1'b0;
        done_next     = 1'b0;
        found_next    = found_reg;
        best_out_next = best_out_reg;
        unique case (state_reg)
            rcme_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.cmd)
                        rcme_pkg::CMD_LOAD:
                        begin
                            wr_en = 1'b1;
                        end
                        rcme_pkg::CMD_ROW, rcme_pkg::CMD_COL:
                        begin
                            if ({1'b0, request.line_index} < lim)
                            begin
                                state_next    = rcme_pkg::ST_SCAN;
                                k_next        = '0;
                                last_next     = rcme_pkg::IdxW'(lim - 5'd1);
                                line_next     = request.line_index;
                                col_mode_next = (request.cmd == rcme_pkg::CMD_COL);
                                clear_max     = 1'b1;
                            end
                            else
                            begin
                                done_next     = 1'b1;
                                found_next    = 1'b0;
                                best_out_next = '0;
                            end
                        end
                        rcme_pkg::CMD_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rcme_pkg::ST_SCAN:
            begin
                samp_next = 1'b1;
                if (k_reg == last_reg)
                begin
                    state_next = rcme_pkg::ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            rcme_pkg::ST_DRAIN:
            begin
                state_next = rcme_pkg::ST_FINISH;
            end
            rcme_pkg::ST_FINISH:
            begin
                state_next    = rcme_pkg::ST_IDLE;
                done_next     = 1'b1;
                found_next    = have;
                best_out_next = have ? best_value : '0;
                kill_live     = have;
            end
            default:
            begin
                state_next = rcme_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcme_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            samp_reg  <= 1'b0;
            live_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            samp_reg  <= samp_next;
            if (wr_en)
            begin
                live_reg[wr_addr] <= 1'b1;
            end
            else if (kill_live)
            begin
                live_reg[best_pos] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        last_reg     <= last_next;
        line_reg     <= line_next;
        col_mode_reg <= col_mode_next;
        found_reg    <= found_next;
        best_out_reg <= best_out_next;
        lv_reg       <= live_reg[rd_addr];
        pos_reg      <= rd_addr;
    end

    // cell memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= request.cell_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        ctl.clear  = clear_max;
        ctl.sample = samp_reg;
        ctl.live   = lv_reg;
        ctl.pos    = pos_reg;
    end

    rcme_max_unit u_max
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .value      (rd_data_reg),
        .have       (have),
        .best_value (best_value),
        .best_pos   (best_pos)
    );

    assign done              = done_reg;
    assign result.found      = found_reg;
    assign result.best_value = best_out_reg;

endmodule

@@ hw/rtl/rcme_checker.sv @@
module rcme_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  rcme_pkg::in_item_t    request,
    input  logic                  done,
    input  rcme_pkg::out_item_t   result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pready
);

    logic query_taken;
    logic load_taken;

    assign query_taken = start && !busy &&
                         ((request.cmd == rcme_pkg::CMD_ROW) ||
                          (request.cmd == rcme_pkg::CMD_COL));
    assign load_taken  = start && !busy && (request.cmd == rcme_pkg::CMD_LOAD);

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.best_value == '0))
        else $error("not-found result carries a nonzero value");

    a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
        query_taken |=> (busy || done))
        else $error("query item neither started a scan nor answered");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_taken |=> !done)
        else $error("load item produced a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable) |-> pready)
        else $error("apb access stalled");

endmodule

bind row_column_max_extract_unit rcme_checker u_rcme_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pready  (pready)
);

@@ test/row_column_max_checker.sv @@
module row_column_max_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  rcme_pkg::in_item_t                request,
    input  logic                              done,
    input  rcme_pkg::out_item_t               result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [rcme_pkg::PaddrW-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output int                                errors,
    output int                                outstanding
);

    logic signed [rcme_pkg::DataW-1:0] cell_data [rcme_pkg::Cells];
    bit                                cell_live [rcme_pkg::Cells];
    logic [rcme_pkg::SizeW-1:0]        size_copy;
    rcme_pkg::out_item_t               expected_max_q [$];
    int                                fail_total;

    initial
    begin
        fail_total = 0;
        size_copy = rcme_pkg::SizeReset;
    end

    function automatic void store_cell(rcme_pkg::in_item_t it);
        int pos;
        pos = int'(it.line_index) * rcme_pkg::Dim + int'(it.cell_column);
        cell_data[pos] = it.cell_value;
        cell_live[pos] = 1'b1;
    endfunction

    // largest live value in the line, lowest position wins a tie; clears its mark
    function automatic rcme_pkg::out_item_t take_line_max(rcme_pkg::cmd_t op, int line);
        rcme_pkg::out_item_t               res;
        int                                lim;
        int                                pos;
        int                                best_pos;
        bit                                have;
        logic signed [rcme_pkg::DataW-1:0] best;
        res = '0;
        have = 1'b0;
        best = '0;
        best_pos = 0;
        lim = (int'(size_copy) > rcme_pkg::Dim) ? rcme_pkg::Dim : int'(size_copy);
        if (line < lim)
        begin
            for (int k = 0; k < lim; k++)
            begin
                pos = (op == rcme_pkg::CMD_ROW) ? line * rcme_pkg::Dim + k :
                                                  k * rcme_pkg::Dim + line;
                if (cell_live[pos] && (!have || cell_data[pos] > best))
                begin
                    have = 1'b1;
                    best = cell_data[pos];
                    best_pos = pos;
                end
            end
        end
        if (have)
        begin
            cell_live[best_pos] = 1'b0;
            res.found = 1'b1;
            res.best_value = best;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        rcme_pkg::out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < rcme_pkg::Cells; i++)
                cell_live[i] = 1'b0;
            size_copy = rcme_pkg::SizeReset;
            expected_max_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_max_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("result with none pending: found %0b value %0d",
                                 result.found, result.best_value);
                end
                else
                begin
                    want = expected_max_q.pop_front();
                    if (result.found !== want.found || result.best_value !== want.best_value)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"mismatch: expected found %0b value %0d, ",
                                      "got found %0b value %0d"},
                                     want.found, want.best_value, result.found,
                                     result.best_value);
                    end
                end
            end
            if (start && !busy)
            begin
                case (request.cmd)
                    rcme_pkg::CMD_LOAD: store_cell(request);
                    rcme_pkg::CMD_ROW, rcme_pkg::CMD_COL:
                        expected_max_q.push_back(take_line_max(request.cmd,
                                                               int'(request.line_index)));
                    default: ;
                endcase
            end
            if (psel && penable && pwrite && pready && paddr == rcme_pkg::RegSizeAddr)
                size_copy = pwdata[rcme_pkg::SizeW-1:0];
        end
        errors <= fail_total;
        outstanding <= expected_max_q.size();
    end

endmodule

@@ test/testbench.sv @@
module testbench;
    import rcme_pkg::*;

    localparam int IdleLimit = 2000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    in_item_t           request;
    logic               done;
    out_item_t          result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PaddrW-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int errors;
    int outstanding;
    int idle_cycles = 0;
    int burst_left;
    bit bursty;
    int cur_size;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    row_column_max_extract_unit dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    row_column_max_checker line_max_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic in_item_t make_item(cmd_t op, int line, int col, logic [31:0] value);
        in_item_t it;
        it.cmd = op;
        it.line_index = line[IdxW-1:0];
        it.cell_column = col[IdxW-1:0];
        it.cell_value = value;
        return it;
    endfunction

    function automatic logic [31:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom();
        else if (r < 85)
            return 32'($urandom_range(0, 15)) - 32'd8;
        else if (r < 93)
            return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        else
            return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
    endfunction

    // mostly loads and queries inside the size in use, a few anywhere
    function automatic in_item_t random_item();
        int   r;
        int   eff;
        int   line;
        int   col;
        cmd_t op;
        eff = (cur_size > Dim) ? Dim : cur_size;
        if (eff == 0)
            eff = Dim;
        r = $urandom_range(0, 99);
        line = ($urandom_range(0, 9) == 0) ? $urandom_range(0, Dim - 1) : $urandom_range(0, eff - 1);
        col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, Dim - 1) : $urandom_range(0, eff - 1);
        if (r < 50)
            op = CMD_LOAD;
        else if (r < 72)
            op = CMD_ROW;
        else if (r < 94)
            op = CMD_COL;
        else
            op = CMD_NONE;
        return make_item(op, line, col, random_value());
    endfunction

    task automatic send_item(in_item_t it);
        start <= 1'b1;
        request <= it;
        do
            @(posedge clk);
        while (busy);
        if (bursty)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 10))
                    @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // only while the block is idle
    task automatic write_size(int value);
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
        repeat (24)
            @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= RegSizeAddr;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_size = value;
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_item(random_item());
    endtask

    initial
    begin
        int phase_sizes [9];
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cur_size = Dim;
        bursty = 1'b0;
        burst_left = 1;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes at the corners, drained one by one
        send_item(make_item(CMD_LOAD, 0, 0, 32'h7fffffff));
        send_item(make_item(CMD_LOAD, 0, 15, 32'h80000000));
        send_item(make_item(CMD_LOAD, 15, 15, 32'hffffffff));
        send_item(make_item(CMD_LOAD, 15, 0, 32'h0));
        send_item(make_item(CMD_ROW, 0, 0, 32'h0));
        send_item(make_item(CMD_ROW, 0, 0, 32'h0));
        send_item(make_item(CMD_ROW, 0, 0, 32'h0));
        send_item(make_item(CMD_COL, 15, 0, 32'h0));
        send_item(make_item(CMD_COL, 0, 0, 32'h0));
        // tie goes to the lowest position
        send_item(make_item(CMD_LOAD, 5, 3, 32'd42));
        send_item(make_item(CMD_LOAD, 5, 9, 32'd42));
        send_item(make_item(CMD_ROW, 5, 0, 32'h0));
        send_item(make_item(CMD_COL, 3, 0, 32'h0));
        send_item(make_item(CMD_COL, 9, 0, 32'h0));
        send_item(make_item(CMD_NONE, 15, 15, 32'hffffffff));
        // reload of a taken cell
        send_item(make_item(CMD_LOAD, 7, 7, 32'd5));
        send_item(make_item(CMD_ROW, 7, 0, 32'h0));
        send_item(make_item(CMD_LOAD, 7, 7, -32'sd5));
        send_item(make_item(CMD_COL, 7, 0, 32'h0));
        // load outside the size in use, line out of range
        write_size(4);
        send_item(make_item(CMD_LOAD, 2, 10, 32'd99));
        send_item(make_item(CMD_ROW, 2, 0, 32'h0));
        send_item(make_item(CMD_ROW, 12, 0, 32'h0));
        // empty size
        write_size(0);
        send_item(make_item(CMD_LOAD, 0, 0, 32'd1));
        send_item(make_item(CMD_COL, 0, 0, 32'h0));
        // size above the grid
        write_size(31);
        send_item(make_item(CMD_ROW, 2, 0, 32'h0));
        send_item(make_item(CMD_ROW, 0, 0, 32'h0));

        phase_sizes = '{1, 16, 0, 31, 5, 12, 3, 16, 0};
        phase_sizes[8] = $urandom_range(1, 16);
        for (int p = 0; p < 9; p++)
        begin
            write_size(phase_sizes[p]);
            bursty = (p % 3 != 2);
            burst_left = $urandom_range(1, 24);
            random_phase(72);
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (32)
            @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
